// File: src/otq_pkg.sv
`default_nettype none

package otq_pkg;

  // Default sizing of the timer table.
  localparam int unsigned CAPACITY      = 16;
  localparam int unsigned ID_BITS       = 16;
  localparam int unsigned INTERVAL_BITS = 24;

  // The millisecond clock and all deadlines are this wide.
  localparam int unsigned TIME_BITS = 32;

  // Field widths of the ports.
  localparam int unsigned ID_PORT_BITS   = 16;
  localparam int unsigned IVAL_PORT_BITS = 24;

  // Saturation value of the time-to-next field.
  localparam logic [IVAL_PORT_BITS-1:0] TTN_MAX = 24'hFF_FFFF;

  // Request codes.
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  // Response kinds.
  localparam logic [1:0] RESP_TICK   = 2'd0;
  localparam logic [1:0] RESP_ADD    = 2'd1;
  localparam logic [1:0] RESP_DELETE = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SELECT,
    ST_FIRE,
    ST_ALLOC,
    ST_DELETE,
    ST_SUMMARY,
    ST_RESP,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// File: src/ordered_timer_queue_unit.sv
`default_nettype none

// Ordered timer queue.
// A request is taken when start_i is high and busy_o is low: req_type_i selects a
// one-millisecond tick, an add (interval_ms_i, recurring_i) or a delete (timer_id_i).
// Request code 3 is taken and ignored, with no result.
// Results appear on the result ports for one cycle each, marked by result_valid_o;
// last_o marks the final result of a request. The receiver cannot stall, so every
// result is consumed in the cycle it is shown.
// One shared subtract/compare unit walks the table one entry per cycle:
//   tick with n expired timers: one selection scan per expired timer plus a final one,
//                               then a summary scan, then max(n,1) results;
//   add: an id-allocation scan, restarted on each id collision, then a summary scan,
//        one result;
//   add to a full table: a summary scan, one result;
//   delete: a search scan, a summary scan, one result.
// busy_o stays high from the accepted request until its last result has been shown,
// so one request is in flight at a time.
// Reset clears the clock, the id counter and all valid bits; the table is empty.
module ordered_timer_queue_unit #(
  parameter int unsigned CAPACITY      = otq_pkg::CAPACITY,
  parameter int unsigned ID_BITS       = otq_pkg::ID_BITS,
  parameter int unsigned INTERVAL_BITS = otq_pkg::INTERVAL_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [23:0] interval_ms_i,
  input  wire logic        recurring_i,
  input  wire logic [15:0] timer_id_i,
  output logic             result_valid_o,
  output logic [1:0]       resp_kind_o,
  output logic             status_o,
  output logic             fired_o,
  output logic [15:0]      result_id_o,
  output logic [23:0]      time_to_next_o,
  output logic             queue_empty_o,
  output logic             last_o
);

  localparam int unsigned IdxW  = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned TimeW = otq_pkg::TIME_BITS;
  localparam int unsigned IdPW  = otq_pkg::ID_PORT_BITS;
  localparam int unsigned IvPW  = otq_pkg::IVAL_PORT_BITS;
  localparam logic [IdxW-1:0]  LastIdx = IdxW'(CAPACITY - 1);
  localparam logic [TimeW-1:0] SignBit = {1'b1, {(TimeW - 1){1'b0}}};

  // Sequencer and control state.
  otq_pkg::state_e state_q, state_d;
  logic [TimeW-1:0]   now_q;
  logic [ID_BITS-1:0] next_id_q;
  logic [CAPACITY-1:0] valid_q;
  logic [CAPACITY-1:0] done_q;
  logic [IdxW-1:0]    idx_q;
  logic               found_q;
  logic [CntW-1:0]    cnt_q;
  logic [IdxW-1:0]    ptr_q;

  // Timer table and the list of ids fired by the current tick.
  logic [TimeW-1:0]         entry_deadline_q [CAPACITY];
  logic [ID_BITS-1:0]       entry_id_q       [CAPACITY];
  logic [INTERVAL_BITS-1:0] entry_period_q   [CAPACITY];
  logic                     entry_repeat_q   [CAPACITY];
  logic [ID_BITS-1:0]       fire_buf_q       [CAPACITY];

  // Captured request and scan results.
  logic [1:0]               req_q;
  logic [INTERVAL_BITS-1:0] ival_q;
  logic                     rec_q;
  logic [ID_BITS-1:0]       tid_q;
  logic [IdxW-1:0]          slot_q;
  logic [ID_BITS-1:0]       cand_q;
  logic                     status_q;
  logic [ID_BITS-1:0]       id_q;
  logic [TimeW-1:0]         best_key_q;
  logic [ID_BITS-1:0]       best_id_q;
  logic [IdxW-1:0]          best_idx_q;

  // Request fields masked to the configured widths.
  logic [INTERVAL_BITS+IvPW-1:0] ival_ext;
  logic [ID_BITS+IdPW-1:0]       tid_ext;
  logic [INTERVAL_BITS-1:0]      ival_in;
  logic [ID_BITS-1:0]            tid_in;

  assign ival_ext = {{INTERVAL_BITS{1'b0}}, interval_ms_i};
  assign tid_ext  = {{ID_BITS{1'b0}}, timer_id_i};
  assign ival_in  = ival_ext[INTERVAL_BITS-1:0];
  assign tid_in   = tid_ext[ID_BITS-1:0];

  // Next id after c, skipping zero on wrap.
  function automatic logic [ID_BITS-1:0] next_cand(input logic [ID_BITS-1:0] c);
    logic [ID_BITS-1:0] n;
    n = c + 1'b1;
    if (n == '0) begin
      n = {{(ID_BITS - 1){1'b0}}, 1'b1};
    end
    return n;
  endfunction

  // Lowest free slot and table-full flag.
  logic [IdxW-1:0] free_idx;
  logic            full;

  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  assign full = &valid_q;

  // Shared compare unit on the entry under the scan pointer.
  logic [TimeW-1:0]   e_diff;
  logic [TimeW-1:0]   e_key;
  logic [ID_BITS-1:0] e_id;
  logic               e_overdue;
  logic               e_better;
  logic [ID_BITS-1:0] cmp_id;
  logic               id_eq;
  logic               e_valid;
  logic               sel_hit;
  logic               sum_hit;
  logic               id_hit;
  logic               idx_last;
  logic [IdxW-1:0]    idx_next;

  always_comb begin
    e_diff    = entry_deadline_q[idx_q] - now_q;
    e_key     = e_diff ^ SignBit;
    e_id      = entry_id_q[idx_q];
    e_overdue = (e_diff == '0) || e_diff[TimeW-1];
    e_better  = !found_q || (e_key < best_key_q) ||
                ((e_key == best_key_q) && (e_id < best_id_q));
    cmp_id    = (state_q == otq_pkg::ST_ALLOC) ? cand_q : tid_q;
    id_eq     = (e_id == cmp_id);
    e_valid   = valid_q[idx_q];
    sel_hit   = e_valid && !done_q[idx_q] && e_overdue && e_better;
    sum_hit   = e_valid && e_better;
    id_hit    = e_valid && id_eq;
    idx_last  = (idx_q == LastIdx);
    idx_next  = idx_last ? '0 : idx_q + 1'b1;
  end

  // Shared adder for new and re-armed deadlines.
  logic [INTERVAL_BITS-1:0] addend;
  logic [TimeW-1:0]         new_deadline;

  always_comb begin
    addend       = (state_q == otq_pkg::ST_FIRE) ? entry_period_q[best_idx_q] : ival_q;
    new_deadline = now_q + {{(TimeW - INTERVAL_BITS){1'b0}}, addend};
  end

  // Last fired id of the current tick.
  logic emit_last;
  assign emit_last = ((CntW'(ptr_q) + CntW'(1)) == cnt_q);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      otq_pkg::ST_IDLE: begin
        if (start_i) begin
          case (req_type_i)
            otq_pkg::REQ_TICK:   state_d = otq_pkg::ST_SELECT;
            otq_pkg::REQ_ADD:    state_d = full ? otq_pkg::ST_SUMMARY : otq_pkg::ST_ALLOC;
            otq_pkg::REQ_DELETE: state_d = otq_pkg::ST_DELETE;
            default:             state_d = otq_pkg::ST_IDLE;
          endcase
        end
      end
      otq_pkg::ST_SELECT: begin
        if (idx_last) begin
          state_d = otq_pkg::ST_FIRE;
        end
      end
      otq_pkg::ST_FIRE: begin
        state_d = found_q ? otq_pkg::ST_SELECT : otq_pkg::ST_SUMMARY;
      end
      otq_pkg::ST_ALLOC: begin
        if (!id_hit && idx_last) begin
          state_d = otq_pkg::ST_SUMMARY;
        end
      end
      otq_pkg::ST_DELETE: begin
        if (idx_last) begin
          state_d = otq_pkg::ST_SUMMARY;
        end
      end
      otq_pkg::ST_SUMMARY: begin
        if (idx_last) begin
          if ((req_q == otq_pkg::REQ_TICK) && (cnt_q != '0)) begin
            state_d = otq_pkg::ST_EMIT;
          end else begin
            state_d = otq_pkg::ST_RESP;
          end
        end
      end
      otq_pkg::ST_RESP: begin
        state_d = otq_pkg::ST_IDLE;
      end
      otq_pkg::ST_EMIT: begin
        if (emit_last) begin
          state_d = otq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = otq_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= otq_pkg::ST_IDLE;
      now_q     <= '0;
      next_id_q <= '0;
      valid_q   <= '0;
      done_q    <= '0;
      idx_q     <= '0;
      found_q   <= 1'b0;
      cnt_q     <= '0;
      ptr_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        otq_pkg::ST_IDLE: begin
          if (start_i) begin
            idx_q   <= '0;
            found_q <= 1'b0;
            cnt_q   <= '0;
            ptr_q   <= '0;
            if (req_type_i == otq_pkg::REQ_TICK) begin
              now_q  <= now_q + 1'b1;
              done_q <= '0;
            end
          end
        end
        otq_pkg::ST_SELECT: begin
          if (sel_hit) begin
            found_q <= 1'b1;
          end
          idx_q <= idx_next;
        end
        otq_pkg::ST_FIRE: begin
          // Retire the selected timer; recurring ones stay valid.
          if (found_q) begin
            cnt_q              <= cnt_q + 1'b1;
            done_q[best_idx_q] <= 1'b1;
            if (!entry_repeat_q[best_idx_q]) begin
              valid_q[best_idx_q] <= 1'b0;
            end
          end
          found_q <= 1'b0;
          idx_q   <= '0;
        end
        otq_pkg::ST_ALLOC: begin
          // A collision restarts the id check with the next candidate.
          if (id_hit) begin
            idx_q <= '0;
          end else if (idx_last) begin
            valid_q[slot_q] <= 1'b1;
            next_id_q       <= cand_q;
            idx_q           <= '0;
          end else begin
            idx_q <= idx_next;
          end
        end
        otq_pkg::ST_DELETE: begin
          if (id_hit) begin
            valid_q[idx_q] <= 1'b0;
          end
          idx_q <= idx_next;
        end
        otq_pkg::ST_SUMMARY: begin
          if (sum_hit) begin
            found_q <= 1'b1;
          end
          idx_q <= idx_next;
        end
        otq_pkg::ST_EMIT: begin
          ptr_q <= ptr_q + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Table contents and captured request data.
  always_ff @(posedge clk_i) begin
    case (state_q)
      otq_pkg::ST_IDLE: begin
        if (start_i) begin
          req_q    <= req_type_i;
          ival_q   <= ival_in;
          rec_q    <= recurring_i;
          tid_q    <= tid_in;
          slot_q   <= free_idx;
          cand_q   <= next_cand(next_id_q);
          id_q     <= '0;
          case (req_type_i)
            otq_pkg::REQ_ADD:    status_q <= full;
            otq_pkg::REQ_DELETE: status_q <= 1'b1;
            default:             status_q <= 1'b0;
          endcase
        end
      end
      otq_pkg::ST_SELECT, otq_pkg::ST_SUMMARY: begin
        if ((state_q == otq_pkg::ST_SELECT) ? sel_hit : sum_hit) begin
          best_key_q <= e_key;
          best_id_q  <= e_id;
          best_idx_q <= idx_q;
        end
      end
      otq_pkg::ST_FIRE: begin
        if (found_q) begin
          fire_buf_q[cnt_q[IdxW-1:0]] <= best_id_q;
          if (entry_repeat_q[best_idx_q]) begin
            entry_deadline_q[best_idx_q] <= new_deadline;
          end
        end
      end
      otq_pkg::ST_ALLOC: begin
        if (id_hit) begin
          cand_q <= next_cand(cand_q);
        end else if (idx_last) begin
          entry_deadline_q[slot_q] <= new_deadline;
          entry_id_q[slot_q]       <= cand_q;
          entry_period_q[slot_q]   <= ival_q;
          entry_repeat_q[slot_q]   <= rec_q;
          id_q                     <= cand_q;
        end
      end
      otq_pkg::ST_DELETE: begin
        if (id_hit) begin
          status_q <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Time to the earliest deadline from the summary scan.
  logic [TimeW-1:0] best_diff;
  logic             best_overdue;
  logic [IvPW-1:0]  ttn;

  always_comb begin
    best_diff    = best_key_q ^ SignBit;
    best_overdue = (best_diff == '0) || best_diff[TimeW-1];
    if (!found_q || best_overdue) begin
      ttn = '0;
    end else if (best_diff > {{(TimeW - IvPW){1'b0}}, otq_pkg::TTN_MAX}) begin
      ttn = otq_pkg::TTN_MAX;
    end else begin
      ttn = best_diff[IvPW-1:0];
    end
  end

  // Result outputs.
  logic [ID_BITS-1:0]      out_id;
  logic [ID_BITS+IdPW-1:0] out_id_ext;

  always_comb begin
    busy_o         = (state_q != otq_pkg::ST_IDLE);
    result_valid_o = 1'b0;
    resp_kind_o    = otq_pkg::RESP_TICK;
    status_o       = 1'b0;
    fired_o        = 1'b0;
    last_o         = 1'b0;
    out_id         = '0;
    case (state_q)
      otq_pkg::ST_RESP: begin
        result_valid_o = 1'b1;
        status_o       = status_q;
        last_o         = 1'b1;
        case (req_q)
          otq_pkg::REQ_ADD: begin
            resp_kind_o = otq_pkg::RESP_ADD;
            out_id      = id_q;
          end
          otq_pkg::REQ_DELETE: begin
            resp_kind_o = otq_pkg::RESP_DELETE;
            out_id      = tid_q;
          end
          default: begin
            resp_kind_o = otq_pkg::RESP_TICK;
          end
        endcase
      end
      otq_pkg::ST_EMIT: begin
        result_valid_o = 1'b1;
        fired_o        = 1'b1;
        last_o         = emit_last;
        out_id         = fire_buf_q[ptr_q];
      end
      default: begin
      end
    endcase
    out_id_ext     = {{IdPW{1'b0}}, out_id};
    result_id_o    = out_id_ext[IdPW-1:0];
    time_to_next_o = ttn;
    queue_empty_o  = !found_q;
  end

endmodule

`default_nettype wire

// File: tb/otq_checker.sv
`timescale 1ns / 100ps

module otq_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [23:0] interval_ms_i,
  input  wire logic        recurring_i,
  input  wire logic [15:0] timer_id_i,
  input  wire logic        result_valid_i,
  input  wire logic [1:0]  resp_kind_i,
  input  wire logic        status_i,
  input  wire logic        fired_i,
  input  wire logic [15:0] result_id_i,
  input  wire logic [23:0] time_to_next_i,
  input  wire logic        queue_empty_i,
  input  wire logic        last_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               expiry_count_o,
  output int               full_count_o
);

  // One result transaction as the block presents it.
  typedef struct packed {
    logic [1:0]  kind;
    logic        status;
    logic        fired;
    logic [15:0] id;
    logic [23:0] ttn;
    logic        empty;
    logic        last;
  } report_t;

  report_t expected_reports[$];

  // Shadow copy of the timer table and the millisecond clock.
  logic [otq_pkg::TIME_BITS-1:0]      clock_ms;
  logic [otq_pkg::ID_PORT_BITS-1:0]   id_counter;
  logic                               slot_live     [otq_pkg::CAPACITY];
  logic [otq_pkg::TIME_BITS-1:0]      slot_deadline [otq_pkg::CAPACITY];
  logic [otq_pkg::ID_PORT_BITS-1:0]   slot_id       [otq_pkg::CAPACITY];
  logic [otq_pkg::IVAL_PORT_BITS-1:0] slot_period   [otq_pkg::CAPACITY];
  logic                               slot_repeat   [otq_pkg::CAPACITY];

  int failures;
  int expiries;
  int full_adds;

  // Deadlines are ordered by their signed distance from the current time.
  function automatic logic [otq_pkg::TIME_BITS-1:0] rank_of(
      input logic [otq_pkg::TIME_BITS-1:0] deadline);
    return (deadline - clock_ms) ^ 32'h8000_0000;
  endfunction

  function automatic logic is_due(input logic [otq_pkg::TIME_BITS-1:0] deadline);
    logic [otq_pkg::TIME_BITS-1:0] delta;
    delta = deadline - clock_ms;
    return (delta == '0) || delta[otq_pkg::TIME_BITS-1];
  endfunction

  // Ties on the deadline are broken by the lower id.
  function automatic logic precedes(input int a, input int b);
    logic [otq_pkg::TIME_BITS-1:0] rank_a;
    logic [otq_pkg::TIME_BITS-1:0] rank_b;
    rank_a = rank_of(slot_deadline[a]);
    rank_b = rank_of(slot_deadline[b]);
    if (rank_a != rank_b) return rank_a < rank_b;
    return slot_id[a] < slot_id[b];
  endfunction

  // Time to the earliest deadline and the empty flag, after the update.
  function automatic void queue_status(output logic [23:0] ttn, output logic empty);
    int best;
    logic [otq_pkg::TIME_BITS-1:0] delta;
    best = -1;
    ttn = '0;
    empty = 1'b1;
    for (int i = 0; i < otq_pkg::CAPACITY; i++) begin
      if (slot_live[i] && (best < 0 || precedes(i, best))) best = i;
    end
    if (best >= 0) begin
      empty = 1'b0;
      delta = slot_deadline[best] - clock_ms;
      if (!is_due(slot_deadline[best])) begin
        ttn = (delta > otq_pkg::TTN_MAX) ? otq_pkg::TTN_MAX : delta[23:0];
      end
    end
  endfunction

  function automatic void push_report(input logic [1:0] kind, input logic status,
                                      input logic fired, input logic [15:0] id,
                                      input logic [23:0] ttn, input logic empty,
                                      input logic last);
    expected_reports.insert(expected_reports.size(),
                            report_t'({kind, status, fired, id, ttn, empty, last}));
  endfunction

  // A tick advances the clock and reports every due timer in deadline order.
  function automatic void predict_tick();
    int due [otq_pkg::CAPACITY];
    logic [15:0] fired_ids [otq_pkg::CAPACITY];
    int n;
    int m;
    int t;
    int e;
    logic [23:0] ttn;
    logic empty;
    n = 0;
    clock_ms = clock_ms + 1;
    for (int i = 0; i < otq_pkg::CAPACITY; i++) begin
      if (slot_live[i] && is_due(slot_deadline[i])) begin
        due[n] = i;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      m = i;
      for (int j = i + 1; j < n; j++) begin
        if (precedes(due[j], due[m])) m = j;
      end
      t = due[i];
      due[i] = due[m];
      due[m] = t;
    end
    // Recurring timers are re-armed only once the whole scan is done.
    for (int i = 0; i < n; i++) begin
      e = due[i];
      fired_ids[i] = slot_id[e];
      if (slot_repeat[e]) slot_deadline[e] = clock_ms + {8'h00, slot_period[e]};
      else slot_live[e] = 1'b0;
    end
    queue_status(ttn, empty);
    if (n == 0) begin
      push_report(otq_pkg::RESP_TICK, 1'b0, 1'b0, '0, ttn, empty, 1'b1);
    end else begin
      for (int i = 0; i < n; i++) begin
        push_report(otq_pkg::RESP_TICK, 1'b0, 1'b1, fired_ids[i], ttn, empty, i == n - 1);
      end
    end
    expiries += n;
  endfunction

  // An add takes the first free slot and the next unused nonzero id.
  function automatic void predict_add(input logic [23:0] ival, input logic rep);
    int slot;
    int tries;
    logic taken;
    logic [23:0] ttn;
    logic empty;
    slot = -1;
    for (int i = 0; i < otq_pkg::CAPACITY; i++) begin
      if (!slot_live[i] && slot < 0) slot = i;
    end
    if (slot < 0) begin
      queue_status(ttn, empty);
      push_report(otq_pkg::RESP_ADD, 1'b1, 1'b0, '0, ttn, empty, 1'b1);
      full_adds++;
      return;
    end
    tries = 0;
    do begin
      id_counter = id_counter + 1'b1;
      if (id_counter == '0) id_counter = 1;
      taken = 1'b0;
      for (int i = 0; i < otq_pkg::CAPACITY; i++) begin
        if (slot_live[i] && slot_id[i] == id_counter) taken = 1'b1;
      end
      tries++;
    end while (taken && tries <= otq_pkg::CAPACITY);
    slot_live[slot]     = 1'b1;
    slot_deadline[slot] = clock_ms + {8'h00, ival};
    slot_id[slot]       = id_counter;
    slot_period[slot]   = ival;
    slot_repeat[slot]   = rep;
    queue_status(ttn, empty);
    push_report(otq_pkg::RESP_ADD, 1'b0, 1'b0, id_counter, ttn, empty, 1'b1);
  endfunction

  // A delete removes the matching timer; id zero never matches.
  function automatic void predict_delete(input logic [15:0] tid);
    logic missing;
    logic [23:0] ttn;
    logic empty;
    missing = 1'b1;
    if (tid != '0) begin
      for (int i = 0; i < otq_pkg::CAPACITY; i++) begin
        if (missing && slot_live[i] && slot_id[i] == tid) begin
          slot_live[i] = 1'b0;
          missing = 1'b0;
        end
      end
    end
    queue_status(ttn, empty);
    push_report(otq_pkg::RESP_DELETE, missing, 1'b0, tid, ttn, empty, 1'b1);
  endfunction

  function automatic string describe(input report_t r);
    return $sformatf("kind=%0d status=%0b fired=%0b id=%0d ttn=%0d empty=%0b last=%0b",
                     r.kind, r.status, r.fired, r.id, r.ttn, r.empty, r.last);
  endfunction

  task automatic note_failure(input string msg);
    if (failures < 10) $display("%0t ns: %s", $time, msg);
    failures++;
  endtask

  // Check result transactions first, then predict for an accepted request.
  always @(posedge clk_i) begin
    report_t got;
    report_t want;
    if (!rst_ni) begin
      clock_ms   = '0;
      id_counter = '0;
      for (int i = 0; i < otq_pkg::CAPACITY; i++) slot_live[i] = 1'b0;
      expected_reports.delete();
    end else begin
      if (result_valid_i) begin
        got = {resp_kind_i, status_i, fired_i, result_id_i, time_to_next_i,
               queue_empty_i, last_i};
        if (expected_reports.size() == 0) begin
          note_failure({"result with nothing expected: ", describe(got)});
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            note_failure({"result mismatch\n  expected ", describe(want),
                          "\n  actual   ", describe(got)});
          end
        end
      end
      if (start_i && !busy_i) begin
        case (req_type_i)
          otq_pkg::REQ_TICK:   predict_tick();
          otq_pkg::REQ_ADD:    predict_add(interval_ms_i, recurring_i);
          otq_pkg::REQ_DELETE: predict_delete(timer_id_i);
          default:             ;
        endcase
      end
    end
    fail_count_o   <= failures;
    pending_o      <= expected_reports.size();
    expiry_count_o <= expiries;
    full_count_o   <= full_adds;
  end

endmodule

// File: tb/ordered_timer_queue_unit_test.sv
`timescale 1ns / 100ps

module ordered_timer_queue_unit_test;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 460;
  localparam int DRAIN_CYCLES = 400;

  // The block takes this code and drops it.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        start_i       = 1'b0;
  logic [1:0]  req_type_i    = otq_pkg::REQ_TICK;
  logic [23:0] interval_ms_i = '0;
  logic        recurring_i   = 1'b0;
  logic [15:0] timer_id_i    = '0;

  logic        busy_o;
  logic        result_valid_o;
  logic [1:0]  resp_kind_o;
  logic        status_o;
  logic        fired_o;
  logic [15:0] result_id_o;
  logic [23:0] time_to_next_o;
  logic        queue_empty_o;
  logic        last_o;

  int fail_count;
  int pending;
  int expiry_count;
  int full_count;

  int tick_count   = 0;
  int add_count    = 0;
  int delete_count = 0;
  int ignored_count = 0;
  int cycle_count  = 0;

  // Ids handed out by the block, kept as targets for delete requests.
  logic [15:0] live_ids[$];

  ordered_timer_queue_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .interval_ms_i  (interval_ms_i),
    .recurring_i    (recurring_i),
    .timer_id_i     (timer_id_i),
    .result_valid_o (result_valid_o),
    .resp_kind_o    (resp_kind_o),
    .status_o       (status_o),
    .fired_o        (fired_o),
    .result_id_o    (result_id_o),
    .time_to_next_o (time_to_next_o),
    .queue_empty_o  (queue_empty_o),
    .last_o         (last_o)
  );

  otq_checker checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .req_type_i     (req_type_i),
    .interval_ms_i  (interval_ms_i),
    .recurring_i    (recurring_i),
    .timer_id_i     (timer_id_i),
    .result_valid_i (result_valid_o),
    .resp_kind_i    (resp_kind_o),
    .status_i       (status_o),
    .fired_i        (fired_o),
    .result_id_i    (result_id_o),
    .time_to_next_i (time_to_next_o),
    .queue_empty_i  (queue_empty_o),
    .last_i         (last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .expiry_count_o (expiry_count),
    .full_count_o   (full_count)
  );

  always #5 clk_i = ~clk_i;

  // Add acknowledgments are sampled mid-cycle, away from the driving edge.
  always @(negedge clk_i) begin
    if (result_valid_o && resp_kind_o == otq_pkg::RESP_ADD && !status_o) begin
      live_ids.insert(live_ids.size(), result_id_o);
    end
  end

  // Present one request and hold it until the block takes it.
  task automatic send_request(input logic [1:0] kind, input logic [23:0] ival,
                              input logic rep, input logic [15:0] id);
    start_i       <= 1'b1;
    req_type_i    <= kind;
    interval_ms_i <= ival;
    recurring_i   <= rep;
    timer_id_i    <= id;
    do @(posedge clk_i); while (busy_o);
    case (kind)
      otq_pkg::REQ_TICK:   tick_count++;
      otq_pkg::REQ_ADD:    add_count++;
      otq_pkg::REQ_DELETE: delete_count++;
      default:             ignored_count++;
    endcase
  endtask

  // Idle until every expected result transaction has arrived.
  task automatic wait_for_drain();
    do @(posedge clk_i); while (pending != 0 || busy_o);
  endtask

  // Mostly ticks, with adds and deletes mixed in; unused fields carry noise.
  task automatic random_request(output logic [1:0] kind, output logic [23:0] ival,
                                output logic rep, output logic [15:0] id);
    int roll;
    int idx;
    ival = 24'($urandom);
    rep  = 1'($urandom);
    id   = 16'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      kind = otq_pkg::REQ_TICK;
    end else if (roll < 78) begin
      kind = otq_pkg::REQ_ADD;
      rep  = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 19))
        0:       ival = '0;
        16, 17:  ival = 24'($urandom_range(41, 200));
        18:      ival = 24'($urandom);
        19:      ival = '1;
        default: ival = 24'($urandom_range(1, 40));
      endcase
    end else if (roll < 96) begin
      kind = otq_pkg::REQ_DELETE;
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        id = '0;
      end else if (roll > 1 && live_ids.size() > 0) begin
        idx = $urandom_range(0, live_ids.size() - 1);
        id  = live_ids[idx];
        live_ids.delete(idx);
      end
    end else begin
      kind = REQ_UNUSED;
    end
  endtask

  initial begin
    logic [1:0]  kind;
    logic [23:0] ival;
    logic        rep;
    logic [15:0] id;
    int          burst;
    int          sent;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Quiet tick on an empty table, then a delete of id zero.
    send_request(otq_pkg::REQ_TICK, '0, 1'b0, '0);
    send_request(otq_pkg::REQ_DELETE, '1, 1'b1, '0);
    // Zero intervals, one recurring, plus the longest interval.
    send_request(otq_pkg::REQ_ADD, '0, 1'b0, '1);
    send_request(otq_pkg::REQ_ADD, '0, 1'b1, '0);
    send_request(otq_pkg::REQ_ADD, '1, 1'b1, '0);
    send_request(otq_pkg::REQ_ADD, 24'd2, 1'b0, '0);
    send_request(otq_pkg::REQ_TICK, '1, 1'b1, '1);
    send_request(otq_pkg::REQ_TICK, '0, 1'b0, '0);
    // Delete a recurring timer, then the same id once it is gone.
    send_request(otq_pkg::REQ_DELETE, '0, 1'b0, 16'd2);
    send_request(otq_pkg::REQ_DELETE, '1, 1'b0, 16'd2);
    send_request(REQ_UNUSED, '1, 1'b1, '1);
    // Fill the table, overflow it, and expire many timers on one tick.
    for (int i = 0; i < 15; i++) send_request(otq_pkg::REQ_ADD, '0, i[0], '0);
    send_request(otq_pkg::REQ_ADD, 24'd5, 1'b0, '0);
    send_request(otq_pkg::REQ_TICK, '0, 1'b0, '0);
    start_i <= 1'b0;
    wait_for_drain();

    // Random bursts separated by gaps, now and then waiting for a full drain.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      while (burst > 0 && sent < RANDOM_ITEMS) begin
        random_request(kind, ival, rep, id);
        send_request(kind, ival, rep, id);
        if (kind != REQ_UNUSED) sent++;
        burst--;
      end
      start_i <= 1'b0;
      if ($urandom_range(0, 9) == 0) wait_for_drain();
      else repeat ($urandom_range(1, 25)) @(posedge clk_i);
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Requests: %0d ticks, %0d adds, %0d deletes, %0d unused codes.",
             tick_count, add_count, delete_count, ignored_count);
    $display("Timer expiries reported: %0d; adds refused by a full table: %0d.",
             expiry_count, full_count);
    if (fail_count == 0 && pending == 0) begin
      $display("ordered_timer_queue_unit_test: PASS");
    end else begin
      $display("%0d failures, %0d results never arrived.", fail_count, pending);
      $display("ordered_timer_queue_unit_test: FAIL");
    end
    $finish;
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles.", cycle_count);
    $display("ordered_timer_queue_unit_test: FAIL");
    $finish;
  end

endmodule

// File: files.f
src/otq_pkg.sv
src/ordered_timer_queue_unit.sv
tb/otq_checker.sv
tb/ordered_timer_queue_unit_test.sv
